// ----- hw/rtl/bmpp_pkg.sv -----
// ============================================================================
// bmpp_pkg: shared types and constants of the BMP 24-bit stream parser
// Holds the item and result records, the result kind and error codes and the
// dimension and tdata widths used by the input stage, parser core and top level.
// ============================================================================
`default_nettype none

package bmpp_pkg;

    // Width of the image dimension fields and of the row counters.
    localparam int DIM_BITS = 14;

    // Packed width of the result tdata: the nine tdata fields, rounded up to bytes.
    localparam int RES_FIELD_BITS = 8 + DIM_BITS + 16 + 1 + 1 + 3 + DIM_BITS + DIM_BITS + 16;
    localparam int TDATA_W        = ((RES_FIELD_BITS + 7) / 8) * 8;

    typedef enum logic [1:0] {
        KIND_PIXEL   = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_ERROR   = 2'd2,
        KIND_ROW_END = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE        = 3'd0,
        ERR_MAGIC       = 3'd1,
        ERR_RESERVED    = 3'd2,
        ERR_COMPRESSION = 3'd3,
        ERR_OFFSET      = 3'd4,
        ERR_TOO_LARGE   = 3'd5
    } err_t;

    // One input request as held in the input register.
    typedef struct packed {
        logic       file_start;
        logic [7:0] data_byte;
    } in_item_t;

    // Input register contents handed to the core.
    typedef struct packed {
        logic     valid;
        in_item_t item;
    } in_stage_t;

    // One result request.
    typedef struct packed {
        kind_t                result_kind;
        logic [7:0]           pixel_byte;
        logic [DIM_BITS-1:0]  row_index;
        logic [15:0]          byte_in_row;
        logic                 row_done;
        logic                 image_done;
        logic                 padding_bad;
        err_t                 error_code;
        logic [DIM_BITS-1:0]  image_width;
        logic [DIM_BITS-1:0]  image_height;
        logic [15:0]          pixel_bits;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bmpp_in_stage.sv -----
// ============================================================================
// bmpp_in_stage: input register of the BMP stream parser
// Captures one byte request from the slave side and holds it until the core
// takes it; refills in the same cycle the core drains it.
// ============================================================================
`default_nettype none

module bmpp_in_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire bmpp_pkg::in_item_t   s_item,
    input  wire logic                 core_take,
    output bmpp_pkg::in_stage_t       stage
);

    logic                 valid_reg;
    bmpp_pkg::in_item_t   item_reg;

    assign s_tready = !valid_reg || core_take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (core_take) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload: load on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/bmpp_core.sv -----
// ============================================================================
// bmpp_core: parse state and result register of the BMP stream parser
// Advances the header, skip, pixel and padding phases by one byte per take
// and loads the result register when the byte produces a result.
// ============================================================================
`default_nettype none

module bmpp_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire bmpp_pkg::in_stage_t  stage,
    output logic                      core_take,
    output logic                      m_valid,
    input  wire logic                 m_tready,
    output bmpp_pkg::result_t         m_result
);

    localparam int D     = bmpp_pkg::DIM_BITS;
    localparam int ROW_W = D + 2;

    localparam logic [31:0] HDR_LEN      = 32'd54;
    localparam logic [31:0] DIM_LIMIT    = 32'((64'd1 << D) - 64'd1);
    localparam logic [31:0] ROW_LIMIT    = 32'h0000_FFFF;
    localparam logic [15:0] MAGIC        = 16'h4d42;
    localparam logic [15:0] DEPTH_RGB24  = 16'd24;
    localparam logic [31:0] POS_MAGIC    = 32'd1;
    localparam logic [31:0] POS_RESERVED = 32'd9;
    localparam logic [31:0] POS_OFFSET   = 32'd13;
    localparam logic [31:0] POS_WIDTH    = 32'd21;
    localparam logic [31:0] POS_HEIGHT   = 32'd25;
    localparam logic [31:0] POS_DEPTH    = 32'd29;
    localparam logic [31:0] POS_COMPRESS = 32'd33;
    localparam logic [31:0] POS_LAST     = 32'd53;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_IDLE
    } phase_t;

    function automatic logic [ROW_W-1:0] row_bytes(input logic [D-1:0] w);
        return {2'b00, w} + {1'b0, w, 1'b0};
    endfunction

    phase_t         phase_reg, phase_next;
    logic [31:0]    pos_reg, pos_next;
    logic [31:0]    shift_reg, shift_next;
    logic [D-1:0]   width_reg, width_next;
    logic [D-1:0]   height_reg, height_next;
    logic [15:0]    depth_reg, depth_next;
    logic [31:0]    offset_reg, offset_next;
    logic [D-1:0]   row_cnt_reg, row_cnt_next;
    logic [15:0]    row_byte_reg, row_byte_next;
    logic [1:0]     pad_cnt_reg, pad_cnt_next;
    logic [7:0]     pad_or_reg, pad_or_next;
    logic           out_valid_reg;
    bmpp_pkg::result_t out_reg;

    // Effective state after an optional file restart.
    phase_t         ph;
    logic [31:0]    pos, shf, off;
    logic [D-1:0]   wid, hgt, rcnt;
    logic [15:0]    dep, rbyte;
    logic [1:0]     pcnt;
    logic [7:0]     por;

    logic [7:0]       b;
    logic [31:0]      shift_in;
    logic [ROW_W-1:0] rb;
    logic [1:0]       pad_len;
    logic             last_row;
    logic [7:0]       por_new;
    logic             res_valid;
    bmpp_pkg::result_t res;

    assign core_take = stage.valid && (!out_valid_reg || m_tready);

    always_comb begin
        ph    = phase_reg;
        pos   = pos_reg;
        shf   = shift_reg;
        wid   = width_reg;
        hgt   = height_reg;
        dep   = depth_reg;
        off   = offset_reg;
        rcnt  = row_cnt_reg;
        rbyte = row_byte_reg;
        pcnt  = pad_cnt_reg;
        por   = pad_or_reg;
        if (stage.item.file_start) begin
            ph    = PH_HEADER;
            pos   = '0;
            shf   = '0;
            wid   = '0;
            hgt   = '0;
            dep   = '0;
            off   = '0;
            rcnt  = '0;
            rbyte = '0;
            pcnt  = '0;
            por   = '0;
        end

        b        = stage.item.data_byte;
        shift_in = {b, shf[31:8]};
        rb       = row_bytes(wid);
        pad_len  = wid[1:0];
        last_row = ({1'b0, rcnt} + {{D{1'b0}}, 1'b1}) >= {1'b0, hgt};
        por_new  = por | b;

        phase_next    = ph;
        pos_next      = (pos == 32'hFFFF_FFFF) ? pos : pos + 32'd1;
        shift_next    = shf;
        width_next    = wid;
        height_next   = hgt;
        depth_next    = dep;
        offset_next   = off;
        row_cnt_next  = rcnt;
        row_byte_next = rbyte;
        pad_cnt_next  = pcnt;
        pad_or_next   = por;

        res             = '0;
        res.result_kind = bmpp_pkg::KIND_PIXEL;
        res.error_code  = bmpp_pkg::ERR_NONE;
        res_valid       = 1'b0;

        case (ph)
            PH_HEADER: begin
                shift_next = shift_in;
                if (pos == POS_MAGIC && shift_in[31:16] != MAGIC) begin
                    res.error_code = bmpp_pkg::ERR_MAGIC;
                end else if (pos == POS_RESERVED && shift_in != 32'd0) begin
                    res.error_code = bmpp_pkg::ERR_RESERVED;
                end else if (pos == POS_OFFSET) begin
                    offset_next = shift_in;
                    if (shift_in < HDR_LEN) begin
                        res.error_code = bmpp_pkg::ERR_OFFSET;
                    end
                end else if (pos == POS_WIDTH) begin
                    if (shift_in > DIM_LIMIT) begin
                        res.error_code = bmpp_pkg::ERR_TOO_LARGE;
                    end else begin
                        width_next = shift_in[D-1:0];
                    end
                end else if (pos == POS_HEIGHT) begin
                    if (shift_in > DIM_LIMIT) begin
                        res.error_code = bmpp_pkg::ERR_TOO_LARGE;
                    end else begin
                        height_next = shift_in[D-1:0];
                    end
                end else if (pos == POS_DEPTH) begin
                    depth_next = shift_in[31:16];
                    if (shift_in[31:16] == DEPTH_RGB24
                        && 32'(rb) > ROW_LIMIT) begin
                        res.error_code = bmpp_pkg::ERR_TOO_LARGE;
                    end
                end else if (pos == POS_COMPRESS && shift_in != 32'd0) begin
                    res.error_code = bmpp_pkg::ERR_COMPRESSION;
                end else if (pos == POS_LAST) begin
                    res_valid        = 1'b1;
                    res.result_kind  = bmpp_pkg::KIND_HEADER;
                    res.image_width  = wid;
                    res.image_height = hgt;
                    res.pixel_bits   = dep;
                    row_cnt_next     = '0;
                    row_byte_next    = '0;
                    pad_cnt_next     = '0;
                    pad_or_next      = '0;
                    if (dep != DEPTH_RGB24 || wid == '0 || hgt == '0) begin
                        phase_next = PH_IDLE;
                    end else if (off == HDR_LEN) begin
                        phase_next = PH_PIXELS;
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                if (res.error_code != bmpp_pkg::ERR_NONE) begin
                    res_valid       = 1'b1;
                    res.result_kind = bmpp_pkg::KIND_ERROR;
                    phase_next      = PH_IDLE;
                end
            end
            PH_SKIP: begin
                if (pos_next >= off) begin
                    phase_next = PH_PIXELS;
                end
            end
            PH_PIXELS: begin
                res_valid       = 1'b1;
                res.result_kind = bmpp_pkg::KIND_PIXEL;
                res.pixel_byte  = b;
                res.row_index   = hgt - {{(D-1){1'b0}}, 1'b1} - rcnt;
                res.byte_in_row = rbyte;
                if ((32'(rbyte) + 32'd1) >= 32'(rb)) begin
                    if (pad_len == 2'd0) begin
                        res.row_done   = 1'b1;
                        res.image_done = last_row;
                        row_cnt_next   = rcnt + {{(D-1){1'b0}}, 1'b1};
                        row_byte_next  = '0;
                        pad_cnt_next   = '0;
                        pad_or_next    = '0;
                        phase_next     = last_row ? PH_IDLE : PH_PIXELS;
                    end else begin
                        phase_next   = PH_PAD;
                        pad_cnt_next = '0;
                        pad_or_next  = '0;
                    end
                end else begin
                    row_byte_next = rbyte + 16'd1;
                end
            end
            PH_PAD: begin
                pad_or_next = por_new;
                if (({1'b0, pcnt} + 3'd1) >= {1'b0, pad_len}) begin
                    res_valid       = 1'b1;
                    res.result_kind = bmpp_pkg::KIND_ROW_END;
                    res.row_index   = hgt - {{(D-1){1'b0}}, 1'b1} - rcnt;
                    res.row_done    = 1'b1;
                    res.padding_bad = (por_new != 8'd0);
                    res.image_done  = last_row;
                    row_cnt_next    = rcnt + {{(D-1){1'b0}}, 1'b1};
                    row_byte_next   = '0;
                    pad_cnt_next    = '0;
                    pad_or_next     = '0;
                    phase_next      = last_row ? PH_IDLE : PH_PIXELS;
                end else begin
                    pad_cnt_next = pcnt + 2'd1;
                end
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            shift_reg     <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            depth_reg     <= '0;
            offset_reg    <= '0;
            row_cnt_reg   <= '0;
            row_byte_reg  <= '0;
            pad_cnt_reg   <= '0;
            pad_or_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (core_take) begin
                phase_reg     <= phase_next;
                pos_reg       <= pos_next;
                shift_reg     <= shift_next;
                width_reg     <= width_next;
                height_reg    <= height_next;
                depth_reg     <= depth_next;
                offset_reg    <= offset_next;
                row_cnt_reg   <= row_cnt_next;
                row_byte_reg  <= row_byte_next;
                pad_cnt_reg   <= pad_cnt_next;
                pad_or_reg    <= pad_or_next;
                out_valid_reg <= res_valid;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load only when a take produces a result.
    always_ff @(posedge aclk) begin
        if (core_take && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    a_error_has_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.result_kind == bmpp_pkg::KIND_ERROR
        |-> out_reg.error_code != bmpp_pkg::ERR_NONE)
        else $error("error result without an error code");

    a_image_done_closes_row: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.image_done |-> out_reg.row_done)
        else $error("image end without row end");

    a_pad_needs_padding: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAD |-> width_reg[1:0] != 2'd0)
        else $error("padding phase for a row without padding");

    a_header_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HEADER |-> pos_reg < HDR_LEN)
        else $error("header phase past the header");

    a_row_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_PIXELS || phase_reg == PH_PAD) |-> row_cnt_reg < height_reg)
        else $error("row counter past the image height");

endmodule

`default_nettype wire

// ----- hw/rtl/bmp_rgb24_stream_parser.sv -----
// ============================================================================
// bmp_rgb24_stream_parser: BMP file byte stream to 24-bit pixel byte stream
// Parses the file and info headers, checks them and emits a header request; for
// 24-bit files it skips to the pixel data and emits each pixel byte with its row
// and byte position, closing rows and the image. A bad header emits a single error request.
// ============================================================================
//
//   channel   direction  tdata                     tuser        tlast
//   s_        in         data_byte [7:0]           file_start   -
//   m_        out        result fields, see below  result_kind  image_done
//
// Cycles: one byte request a clock sustained while m_tready stays high; a
//   byte passes the input register and the parse logic into the result
//   register. Each byte yields zero or one result request.
// Reset: aresetn low clears the valid flags of both registers and puts the parser at the start
//   of a file; file_start restarts it at the marked byte.
// Stalls: with m_tready low the result is held, the input register still
//   takes one more byte, and s_tready drops once both are full.
// ============================================================================
`default_nettype none

module bmp_rgb24_stream_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,  // [7:0] data_byte
    input  wire logic                          s_tuser,  // [0] file_start

    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // From bit 0 up: pixel_byte, row_index, byte_in_row, row_done, padding_bad,
    // error_code, image_width, image_height, pixel_bits, zero fill.
    output logic [bmpp_pkg::TDATA_W-1:0]       m_tdata,
    output logic [1:0]                         m_tuser,  // [1:0] result_kind
    output logic                               m_tlast   // image_done
);

    bmpp_pkg::in_item_t   s_item;
    bmpp_pkg::in_stage_t  stage;
    bmpp_pkg::result_t    result;
    logic                 core_take;

    assign s_item.data_byte  = s_tdata;
    assign s_item.file_start = s_tuser;

    // Hold the accepted byte until the core takes it.
    bmpp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .core_take (core_take),
        .stage     (stage)
    );

    // Advance the parse state and register the result.
    bmpp_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .stage     (stage),
        .core_take (core_take),
        .m_valid   (m_tvalid),
        .m_tready  (m_tready),
        .m_result  (result)
    );

    // Pack the result fields, lowest field first, zero fill on top.
    assign m_tdata = {
        {(bmpp_pkg::TDATA_W - bmpp_pkg::RES_FIELD_BITS){1'b0}},
        result.pixel_bits,
        result.image_height,
        result.image_width,
        result.error_code,
        result.padding_bad,
        result.row_done,
        result.byte_in_row,
        result.row_index,
        result.pixel_byte
    };
    assign m_tuser = result.result_kind;
    assign m_tlast = result.image_done;

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the BMP 24-bit stream parser
// Feeds whole and broken BMP files a byte per request, predicts every header,
// error, pixel and row-end request in a scoreboard, and checks each result
// request field by field under several sender-idle and receiver-stall mixes.
// ============================================================================

module tb;
    import bmpp_pkg::*;

    localparam int RANDOM_BYTES    = 540;
    localparam int LIMIT_CYCLES    = 400000;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 8;

    localparam int          HEADER_BYTES = 54;
    localparam logic [15:0] BMP_MAGIC    = 16'h4D42;
    localparam int          DEPTH_RGB24  = 24;
    localparam logic [31:0] DIM_MAX      = (32'd1 << DIM_BITS) - 32'd1;

    // Byte offsets of the header fields.
    localparam int OFS_RESERVED = 6;
    localparam int OFS_OFFSET   = 10;
    localparam int OFS_WIDTH    = 18;
    localparam int OFS_HEIGHT   = 22;
    localparam int OFS_DEPTH    = 28;
    localparam int OFS_COMPRESS = 30;

    typedef enum logic [2:0] {
        ST_HEADER, ST_SKIP, ST_PIXELS, ST_PADDING, ST_IDLE
    } parse_state_t;

    // m_tdata layout, lowest field last.
    typedef struct packed {
        logic [TDATA_W-RES_FIELD_BITS-1:0] fill;
        logic [15:0]                       pixel_bits;
        logic [DIM_BITS-1:0]               image_height;
        logic [DIM_BITS-1:0]               image_width;
        logic [2:0]                        error_code;
        logic                              padding_bad;
        logic                              row_done;
        logic [15:0]                       byte_in_row;
        logic [DIM_BITS-1:0]               row_index;
        logic [7:0]                        pixel_byte;
    } m_data_t;

    class bmp_parse_scoreboard;
        logic [31:0]         stream_pos;
        logic [31:0]         field_sr;
        logic [31:0]         pix_offset;
        parse_state_t        state;
        logic [DIM_BITS-1:0] width_r;
        logic [DIM_BITS-1:0] height_r;
        logic [DIM_BITS-1:0] row_cnt;
        logic [15:0]         depth_r;
        logic [15:0]         row_byte_cnt;
        logic [1:0]          pad_cnt;
        logic [7:0]          pad_or;
        result_t             parse_results_q[$];
        int                  mismatches;
        int                  kind_seen[4];

        function new();
            mismatches = 0;
            foreach (kind_seen[k]) kind_seen[k] = 0;
            restart();
        endfunction

        function void restart();
            stream_pos   = '0;
            field_sr     = '0;
            pix_offset   = '0;
            state        = ST_HEADER;
            width_r      = '0;
            height_r     = '0;
            row_cnt      = '0;
            depth_r      = '0;
            row_byte_cnt = '0;
            pad_cnt      = '0;
            pad_or       = '0;
        endfunction

        function int pending();
            return parse_results_q.size();
        endfunction

        function int row_bytes();
            return 3 * int'(width_r);
        endfunction

        function int pad_len();
            return (4 - row_bytes() % 4) % 4;
        endfunction

        // Rows are stored bottom-up; report them from the top.
        function logic [DIM_BITS-1:0] current_row();
            return height_r - 1'b1 - row_cnt;
        endfunction

        function logic close_row();
            logic last_row;
            last_row     = (int'(row_cnt) + 1 >= int'(height_r));
            row_cnt      = row_cnt + 1'b1;
            row_byte_cnt = '0;
            pad_cnt      = '0;
            pad_or       = '0;
            state        = last_row ? ST_IDLE : ST_PIXELS;
            return last_row;
        endfunction

        // Advance the parser by one accepted byte; queue the result it yields.
        function void parse_byte(logic [7:0] b, logic fs);
            logic [31:0] pos;
            err_t        err;
            result_t     r;
            bit          emit;
            if (fs)
                restart();
            r    = '0;
            err  = ERR_NONE;
            emit = 1'b0;
            pos  = stream_pos;
            if (stream_pos != 32'hFFFF_FFFF)
                stream_pos = stream_pos + 32'd1;

            case (state)
                ST_HEADER: begin
                    field_sr = {b, field_sr[31:8]};
                    if (pos == 1 && field_sr[31:16] != BMP_MAGIC) begin
                        err = ERR_MAGIC;
                    end else if (pos == 9 && field_sr != 0) begin
                        err = ERR_RESERVED;
                    end else if (pos == 13) begin
                        pix_offset = field_sr;
                        if (pix_offset < HEADER_BYTES)
                            err = ERR_OFFSET;
                    end else if (pos == 21 || pos == 25) begin
                        if (field_sr > DIM_MAX)
                            err = ERR_TOO_LARGE;
                        else if (pos == 21)
                            width_r = field_sr[DIM_BITS-1:0];
                        else
                            height_r = field_sr[DIM_BITS-1:0];
                    end else if (pos == 29) begin
                        depth_r = field_sr[31:16];
                        if (depth_r == DEPTH_RGB24 && row_bytes() > 65535)
                            err = ERR_TOO_LARGE;
                    end else if (pos == 33 && field_sr != 0) begin
                        err = ERR_COMPRESSION;
                    end

                    if (err != ERR_NONE) begin
                        r.result_kind = KIND_ERROR;
                        r.error_code  = err;
                        state         = ST_IDLE;
                        emit          = 1'b1;
                    end else if (pos == HEADER_BYTES - 1) begin
                        r.result_kind  = KIND_HEADER;
                        r.image_width  = width_r;
                        r.image_height = height_r;
                        r.pixel_bits   = depth_r;
                        emit           = 1'b1;
                        row_cnt        = '0;
                        row_byte_cnt   = '0;
                        pad_cnt        = '0;
                        pad_or         = '0;
                        if (depth_r != DEPTH_RGB24 || width_r == 0 || height_r == 0)
                            state = ST_IDLE;
                        else if (pix_offset == HEADER_BYTES)
                            state = ST_PIXELS;
                        else
                            state = ST_SKIP;
                    end
                end
                ST_SKIP: begin
                    if (stream_pos >= pix_offset)
                        state = ST_PIXELS;
                end
                ST_PIXELS: begin
                    r.result_kind = KIND_PIXEL;
                    r.pixel_byte  = b;
                    r.row_index   = current_row();
                    r.byte_in_row = row_byte_cnt;
                    emit          = 1'b1;
                    if (int'(row_byte_cnt) + 1 >= row_bytes()) begin
                        if (pad_len() == 0) begin
                            r.row_done   = 1'b1;
                            r.image_done = close_row();
                        end else begin
                            state   = ST_PADDING;
                            pad_cnt = '0;
                            pad_or  = '0;
                        end
                    end else begin
                        row_byte_cnt = row_byte_cnt + 16'd1;
                    end
                end
                ST_PADDING: begin
                    pad_or = pad_or | b;
                    if (int'(pad_cnt) + 1 >= pad_len()) begin
                        r.result_kind = KIND_ROW_END;
                        r.row_index   = current_row();
                        r.row_done    = 1'b1;
                        r.padding_bad = (pad_or != 0);
                        r.image_done  = close_row();
                        emit          = 1'b1;
                    end else begin
                        pad_cnt = pad_cnt + 2'd1;
                    end
                end
                default: state = ST_IDLE;
            endcase

            if (emit)
                parse_results_q.push_back(r);
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] kind, m_data_t d, logic last);
            result_t want;
            if (parse_results_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, kind);
                return;
            end
            want = parse_results_q.pop_front();
            kind_seen[want.result_kind]++;
            compare("result_kind",  want.result_kind,  kind);
            compare("pixel_byte",   want.pixel_byte,   d.pixel_byte);
            compare("row_index",    want.row_index,    d.row_index);
            compare("byte_in_row",  want.byte_in_row,  d.byte_in_row);
            compare("row_done",     want.row_done,     d.row_done);
            compare("image_done",   want.image_done,   last);
            compare("padding_bad",  want.padding_bad,  d.padding_bad);
            compare("error_code",   want.error_code,   d.error_code);
            compare("image_width",  want.image_width,  d.image_width);
            compare("image_height", want.image_height, d.image_height);
            compare("pixel_bits",   want.pixel_bits,   d.pixel_bits);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, block
    // ------------------------------------------------------------------------
    logic               aclk     = 1'b0;
    logic               aresetn  = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;
    logic [1:0]         m_tuser;
    logic               m_tlast;

    always #1 aclk = ~aclk;

    bmp_rgb24_stream_parser i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    bmp_parse_scoreboard sb;
    int   bytes_sent     = 0;
    int   files_sent     = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    bit   hold_req       = 1'b0;
    int   hold_left      = 0;
    int   cycles         = 0;
    logic [7:0] file_q[$];

    // ------------------------------------------------------------------------
    // Monitor: predict on each byte request, check each result request
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.parse_byte(s_tdata, s_tuser);
                bytes_sent++;
            end
            if (m_tvalid && m_tready)
                sb.check_result(m_tuser, m_data_t'(m_tdata), m_tlast);
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results still expected",
                     cycles, sb.pending());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when asked for one.
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Sender tasks and file builders (called at a falling edge)
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic fs);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= fs;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic send_file(input logic first_fs);
        foreach (file_q[i])
            send_byte(file_q[i], (i == 0) ? first_fs : 1'b0);
        files_sent++;
    endtask

    // Drop valid and hold until every predicted result has come back.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (sb.pending() != 0)
            @(negedge aclk);
    endtask

    function automatic void add_random(int n);
        repeat (n) file_q.push_back(8'($urandom));
    endfunction

    function automatic void put_le(int at, logic [31:0] v, int n);
        for (int i = 0; i < n; i++)
            file_q[at + i] = v[8*i +: 8];
    endfunction

    // Fields the parser never checks keep random content.
    function automatic void build_header(logic [31:0] w, logic [31:0] h,
                                         logic [31:0] bpp, logic [31:0] offs);
        file_q.delete();
        add_random(HEADER_BYTES);
        put_le(0, 32'(BMP_MAGIC), 2);
        put_le(OFS_RESERVED, 32'd0, 4);
        put_le(OFS_OFFSET, offs, 4);
        put_le(OFS_WIDTH, w, 4);
        put_le(OFS_HEIGHT, h, 4);
        put_le(OFS_DEPTH, bpp, 2);
        put_le(OFS_COMPRESS, 32'd0, 4);
    endfunction

    function automatic void add_rows(int w, int nrows, int bad_pct);
        int pad;
        pad = (4 - (3 * w) % 4) % 4;
        repeat (nrows) begin
            add_random(3 * w);
            if (pad > 0 && $urandom_range(99) < bad_pct) begin
                add_random(pad);
                file_q[file_q.size() - 1 - $urandom_range(pad - 1)] = 8'($urandom_range(1, 255));
            end else begin
                repeat (pad) file_q.push_back(8'h00);
            end
        end
    endfunction

    function automatic void truncate_to(int n);
        while (file_q.size() > n)
            void'(file_q.pop_back());
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int   rand_base;
        int   mix;
        int   cur_mix;
        int   sel;
        int   w;
        int   h;
        logic [31:0] bpp;
        err_t bad;

        sb = new();
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed files. The first one goes in without file_start.
        build_header(1, 1, DEPTH_RGB24, HEADER_BYTES);
        add_rows(1, 1, 0);
        send_file(1'b0);

        // Gap before the pixels, two padding bytes, nonzero padding in every row.
        build_header(2, 2, DEPTH_RGB24, HEADER_BYTES + 4);
        add_random(4);
        add_rows(2, 2, 100);
        send_file(1'b1);

        // Three padding bytes, then trailing bytes the parser drops.
        build_header(3, 3, DEPTH_RGB24, HEADER_BYTES);
        add_rows(3, 3, 0);
        add_random(3);
        send_file(1'b1);

        // No padding: the last pixel byte closes the row.
        build_header(4, 2, DEPTH_RGB24, HEADER_BYTES);
        add_rows(4, 2, 0);
        send_file(1'b1);

        // Files with a bad header field, both magic bytes; reserved and compression both bad, first wins.
        build_header(2, 2, DEPTH_RGB24, HEADER_BYTES);
        file_q[0] = 8'h41;
        send_file(1'b1);
        build_header(2, 2, DEPTH_RGB24, HEADER_BYTES);
        file_q[1] = 8'hCD;
        send_file(1'b1);
        build_header(2, 2, DEPTH_RGB24, HEADER_BYTES);
        file_q[OFS_RESERVED + 3] = 8'h80;
        file_q[OFS_COMPRESS] = 8'h01;
        send_file(1'b1);
        build_header(2, 2, DEPTH_RGB24, HEADER_BYTES - 1);
        send_file(1'b1);
        build_header(DIM_MAX + 1, 2, DEPTH_RGB24, HEADER_BYTES);
        send_file(1'b1);
        build_header(2, 32'hFFFF_FFFF, DEPTH_RGB24, HEADER_BYTES);
        send_file(1'b1);
        build_header(2, 2, DEPTH_RGB24, HEADER_BYTES);
        put_le(OFS_COMPRESS, 32'd1, 4);
        send_file(1'b1);

        // Other depths report the header only.
        build_header(3, 2, 8, HEADER_BYTES);
        add_random(10);
        send_file(1'b1);
        build_header(DIM_MAX, DIM_MAX, 32'h0000_FFFF, HEADER_BYTES);
        add_random(4);
        send_file(1'b1);

        // Empty images.
        build_header(0, 5, DEPTH_RGB24, HEADER_BYTES);
        add_random(6);
        send_file(1'b1);
        build_header(5, 0, DEPTH_RGB24, HEADER_BYTES);
        add_random(6);
        send_file(1'b1);

        // Largest image, cut short by the next file.
        build_header(DIM_MAX, DIM_MAX, DEPTH_RGB24, HEADER_BYTES);
        add_random(20);
        send_file(1'b1);

        // Largest pixel offset: everything after the header is skipped.
        build_header(1, 1, DEPTH_RGB24, 32'hFFFF_FFFF);
        add_random(10);
        send_file(1'b1);

        // Restart in the middle of a header.
        build_header(5, 1, DEPTH_RGB24, HEADER_BYTES);
        truncate_to(30);
        send_file(1'b1);
        build_header(5, 1, DEPTH_RGB24, HEADER_BYTES);
        add_rows(5, 1, 50);
        send_file(1'b1);

        // Random files in four idle/stall mixes, each mix visited in turn.
        rand_base = bytes_sent;
        cur_mix   = -1;
        while (bytes_sent < rand_base + RANDOM_BYTES || cur_mix < 3) begin
            mix = (bytes_sent - rand_base) * 4 / RANDOM_BYTES;
            if (mix > 3)
                mix = 3;
            if (mix > cur_mix) begin
                // Pause the sender until all is in, then hold off the receiver
                // while the next file streams in behind it.
                cur_mix = cur_mix + 1;
                wait_drained();
                send_idle_pct  = (cur_mix == 1) ? 55 : (cur_mix == 3) ? 29 : 0;
                recv_stall_pct = (cur_mix == 2) ? 55 : (cur_mix == 3) ? 29 : 0;
                hold_req = 1'b1;
            end

            sel = $urandom_range(99);
            w   = ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 7);
            h   = $urandom_range(1, 4);
            if (sel < 65) begin
                sel = $urandom_range(1) ? 0 : $urandom_range(1, 8);
                build_header(w, h, DEPTH_RGB24, HEADER_BYTES + sel);
                add_random(sel);
                add_rows(w, h, 25);
                if ($urandom_range(4) == 0)
                    add_random($urandom_range(1, 6));
                if ($urandom_range(9) == 0)
                    truncate_to($urandom_range(1, file_q.size() - 1));
                send_file(1'b1);
            end else if (sel < 75) begin
                bpp = $urandom_range(1) ? (32'd1 << $urandom_range(0, 5))
                                        : 32'($urandom_range(0, 65535));
                if (bpp == DEPTH_RGB24)
                    bpp = 32'd32;
                build_header(w, h, bpp, HEADER_BYTES);
                add_random($urandom_range(0, 6));
                send_file(1'b1);
            end else if (sel < 92) begin
                build_header(w, h, DEPTH_RGB24, HEADER_BYTES);
                bad = err_t'($urandom_range(ERR_MAGIC, ERR_TOO_LARGE));
                case (bad)
                    ERR_MAGIC: begin
                        sel = $urandom_range(1);
                        file_q[sel] = file_q[sel] ^ 8'($urandom_range(1, 255));
                    end
                    ERR_RESERVED:
                        file_q[$urandom_range(OFS_RESERVED, OFS_RESERVED + 3)] =
                            8'($urandom_range(1, 255));
                    ERR_COMPRESSION:
                        file_q[$urandom_range(OFS_COMPRESS, OFS_COMPRESS + 3)] =
                            8'($urandom_range(1, 255));
                    ERR_OFFSET:
                        put_le(OFS_OFFSET, $urandom_range(0, HEADER_BYTES - 1), 4);
                    default:
                        put_le($urandom_range(1) ? OFS_WIDTH : OFS_HEIGHT,
                               $urandom | (DIM_MAX + 32'd1), 4);
                endcase
                truncate_to($urandom_range(OFS_COMPRESS + 4, HEADER_BYTES));
                send_file(1'b1);
            end else begin
                // Noise, sometimes with a stray file_start.
                repeat ($urandom_range(1, 10))
                    send_byte(8'($urandom), $urandom_range(3) == 0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d files in %0d byte requests over four idle/stall mixes.",
                 files_sent, bytes_sent);
        $display("Checked %0d pixel bytes, %0d headers, %0d errors, %0d padded row ends.",
                 sb.kind_seen[KIND_PIXEL], sb.kind_seen[KIND_HEADER],
                 sb.kind_seen[KIND_ERROR], sb.kind_seen[KIND_ROW_END]);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
